// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the record deframer. Both macros sample on the rising
// edge of clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General concurrent property.
`define RDMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RDMC_ASSERT_IMPLY(label, ante, cons, msg) \
	`RDMC_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/rdmc_pkg.sv =====
`default_nettype none
package rdmc_pkg;

	localparam logic [31:0] CRC_POLY     = 32'h82F63B78;
	localparam logic [31:0] MASK_DELTA   = 32'hA282EAD8;
	localparam logic [63:0] FRAME_BYTES  = 64'd16;
	localparam int          OUT_TDATA_W  = 144;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_LEN_CRC_ERR = 3'd1,
		ST_PAY_CRC_ERR = 3'd2,
		ST_TRUNCATED   = 3'd3,
		ST_CLEAN_END   = 3'd4
	} status_t;

	// One result as produced by the parser, before the running offset is added.
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [63:0] record_length;
	} rec_token_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rdmc_front.sv =====
`default_nettype none
module rdmc_front import rdmc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_stream,
	output logic            push,
	output rec_token_t      token
);

	typedef enum logic [1:0] {
		PH_LEN     = 2'd0,
		PH_LEN_CRC = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_PAY_CRC = 2'd3
	} phase_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [31:0] mask_crc(input logic [31:0] crc);
		logic [31:0] c;
		c = ~crc;
		return {c[14:0], c[31:15]} + MASK_DELTA;
	endfunction

	phase_t      phase_q, phase_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [63:0] len_q, len_n;
	logic [63:0] rem_q, rem_n;
	logic [31:0] crc_q, crc_n;
	logic [31:0] rx_q, rx_n;
	logic [31:0] rx_cur;
	logic        crc_match;

	// Received CRC field including the byte of this beat.
	always_comb begin
		rx_cur = rx_q;
		rx_cur[{cnt_q[1:0], 3'b000} +: 8] = in_byte;
	end

	assign crc_match = (rx_cur == mask_crc(crc_q));

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		rem_n   = rem_q;
		crc_n   = crc_q;
		rx_n    = rx_q;
		push    = 1'b0;
		token   = '0;
		if (accept) begin
			if (end_of_stream) begin
				push      = 1'b1;
				token.kind = 1'b1;
				if (phase_q == PH_LEN && cnt_q == 3'd0) begin
					token.status = ST_CLEAN_END;
				end else begin
					token.status        = ST_TRUNCATED;
					token.record_length = (phase_q == PH_LEN) ? 64'd0 : len_q;
				end
				phase_n = PH_LEN;
				cnt_n   = '0;
				len_n   = '0;
				rem_n   = '0;
				crc_n   = '1;
				rx_n    = '0;
			end else begin
				case (phase_q)
					PH_LEN: begin
						len_n[{cnt_q, 3'b000} +: 8] = in_byte;
						crc_n = crc32c_byte(crc_q, in_byte);
						cnt_n = cnt_q + 3'd1;
						if (cnt_q == 3'd7) begin
							phase_n = PH_LEN_CRC;
							rx_n    = '0;
						end
					end
					PH_LEN_CRC: begin
						rx_n  = rx_cur;
						cnt_n = cnt_q + 3'd1;
						if (cnt_q[1:0] == 2'd3) begin
							cnt_n = '0;
							rx_n  = '0;
							if (!crc_match) begin
								push                = 1'b1;
								token.kind          = 1'b1;
								token.status        = ST_LEN_CRC_ERR;
								token.record_length = len_q;
								phase_n = PH_LEN;
								len_n   = '0;
								rem_n   = '0;
								crc_n   = '1;
							end else begin
								crc_n   = '1;
								rem_n   = len_q;
								phase_n = (len_q == 64'd0) ? PH_PAY_CRC : PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						crc_n = crc32c_byte(crc_q, in_byte);
						rem_n = rem_q - 64'd1;
						if (rem_q == 64'd1) begin
							phase_n = PH_PAY_CRC;
							cnt_n   = '0;
							rx_n    = '0;
						end
						push               = 1'b1;
						token.payload_byte = in_byte;
					end
					PH_PAY_CRC: begin
						rx_n  = rx_cur;
						cnt_n = cnt_q + 3'd1;
						if (cnt_q[1:0] == 2'd3) begin
							push                = 1'b1;
							token.kind          = 1'b1;
							token.status        = crc_match ? ST_OK : ST_PAY_CRC_ERR;
							token.record_length = len_q;
							phase_n = PH_LEN;
							cnt_n   = '0;
							len_n   = '0;
							rem_n   = '0;
							crc_n   = '1;
							rx_n    = '0;
						end
					end
					default: begin
						phase_n = PH_LEN;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			cnt_q   <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			crc_q   <= '1;
			rx_q    <= '0;
		end else begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			rem_q   <= rem_n;
			crc_q   <= crc_n;
			rx_q    <= rx_n;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rdmc_fifo.sv =====
`default_nettype none
module rdmc_fifo import rdmc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire rec_token_t  wdata,
	input  wire logic        pop,
	output rec_token_t       rdata,
	output fifo_status_t     stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_token_t    mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rdmc_back.sv =====
`default_nettype none
module rdmc_back import rdmc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire rec_token_t              token,
	input  wire fifo_status_t            stat,
	output logic                         pop,
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
	output logic                         m_axis_tuser
);

	logic        valid_q;
	logic [63:0] total_q;
	logic        kind_q;
	logic [7:0]  byte_q;
	status_t     status_q;
	logic [63:0] len_q;
	logic        good_rec;

	assign pop      = !stat.empty && (!valid_q || m_axis_tready);
	assign good_rec = token.kind && (token.status == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (good_rec) begin
					total_q <= total_q + token.record_length + FRAME_BYTES;
				end
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= token.kind;
			byte_q   <= token.payload_byte;
			status_q <= token.status;
			len_q    <= token.record_length;
		end
	end

	// The running total is already the value that belongs to the held beat.
	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tdata  = {5'b0, total_q, len_q, status_q, byte_q};

endmodule
`default_nettype wire

// ===== hw/rtl/record_deframer_masked_crc32c.sv =====
`default_nettype none
// Record deframer with masked CRC32C checks. The input stream carries one byte
// per beat; a beat with tlast set marks the end of the stream and carries no
// byte. Each record is an 8-byte little-endian length, a 4-byte masked CRC32C
// of that length, the payload, and a 4-byte masked CRC32C of the payload (the
// mask rotates the finalized CRC right by 15 and adds 0xA282EAD8). Payload
// bytes come out one per beat with tuser low; each record ends with one status
// beat (tuser high) that reports ok, a length or payload CRC mismatch, a
// truncated stream or a clean end, with the header length and the running
// byte count of good records (header and trailer included, modulo 2^64).
// After any status the parser starts again at a length field. The block takes
// one byte per cycle while the queue has room, limited by the bytewise CRC32C
// update in the parser; results pass through a FIFO_DEPTH-entry queue and an
// output register. The input stalls only when that queue is full. No clearing
// pass is needed after reset.
`include "assert_macros.svh"
module record_deframer_masked_crc32c import rdmc_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,  // [7:0] in_byte
	input  wire logic                   s_axis_tlast,  // end_of_stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [7:0] payload_byte, [10:8] status, [74:11] record_length,
	// [138:75] stream_offset, [143:139] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                        m_axis_tuser   // kind
);

	logic         accept;
	logic         push;
	logic         pop;
	rec_token_t   token_w;
	rec_token_t   token_r;
	fifo_status_t fifo_stat;

	// A beat is taken whenever the queue has room, whether or not it yields a
	// result; the parser state only moves on accepted beats.
	assign s_axis_tready = !fifo_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	rdmc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (s_axis_tdata),
		.end_of_stream (s_axis_tlast),
		.push          (push),
		.token         (token_w)
	);

	rdmc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (token_w),
		.pop    (pop),
		.rdata  (token_r),
		.stat   (fifo_stat)
	);

	// The back end keeps the running offset and holds the output beat.
	rdmc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.token         (token_r),
		.stat          (fifo_stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// The parser must never produce a result into a full queue.
	`RDMC_ASSERT_IMPLY(a_no_push_full, push, !fifo_stat.full, "result pushed into full queue")
	// The back end must never take from an empty queue.
	`RDMC_ASSERT_IMPLY(a_no_pop_empty, pop, !fifo_stat.empty, "pop from empty queue")
	// A payload beat always carries a zero status field.
	`RDMC_ASSERT_IMPLY(a_payload_status, m_axis_tvalid && !m_axis_tuser,
		m_axis_tdata[10:8] == ST_OK, "payload beat with nonzero status")

endmodule
`default_nettype wire

// ===== verif/deframer_check_pkg.sv =====
`timescale 1ns / 1ps
package deframer_check_pkg;
	import rdmc_pkg::*;

	typedef enum logic [1:0] {
		PARSE_LENGTH,
		PARSE_LENGTH_CRC,
		PARSE_PAYLOAD,
		PARSE_PAYLOAD_CRC
	} parse_phase_t;

	localparam logic        KIND_PAYLOAD = 1'b0;
	localparam logic        KIND_STATUS  = 1'b1;
	localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [63:0] record_length;
		logic [63:0] stream_offset;
	} deframe_beat_t;

	// Reflected Castagnoli CRC, one byte at a time.
	function automatic logic [31:0] crc32c_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		int i;
		c = crc ^ {24'd0, b};
		for (i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Finalize, rotate right by 15 and add the mask delta.
	function automatic logic [31:0] crc32c_masked(input logic [31:0] crc_reg);
		logic [31:0] c;
		c = ~crc_reg;
		return {c[14:0], c[31:15]} + MASK_DELTA;
	endfunction

	class deframe_tracker;
		parse_phase_t  parse_phase;
		logic [3:0]    field_count;
		logic [63:0]   header_len;
		logic [63:0]   bytes_left;
		logic [31:0]   crc_reg;
		logic [31:0]   crc_field;
		logic [63:0]   good_bytes;
		deframe_beat_t awaited_results[$];
		int unsigned   errors;
		int unsigned   beats_seen;

		function new();
			good_bytes = '0;
			errors     = 0;
			beats_seen = 0;
			restart();
		endfunction

		function void restart();
			parse_phase = PARSE_LENGTH;
			field_count = '0;
			header_len  = '0;
			bytes_left  = '0;
			crc_reg     = CRC_INIT;
			crc_field   = '0;
		endfunction

		function void push_beat(logic kind, logic [7:0] b, status_t st, logic [63:0] len);
			deframe_beat_t beat;
			beat.kind          = kind;
			beat.payload_byte  = b;
			beat.status        = st;
			beat.record_length = len;
			beat.stream_offset = good_bytes;
			awaited_results.push_back(beat);
		endfunction

		// Called for every beat accepted on the input side.
		function void take_byte(logic [7:0] b, logic eos);
			if (eos) begin
				if (parse_phase == PARSE_LENGTH && field_count == 0)
					push_beat(KIND_STATUS, 8'd0, ST_CLEAN_END, 64'd0);
				else
					push_beat(KIND_STATUS, 8'd0, ST_TRUNCATED,
						(parse_phase == PARSE_LENGTH) ? 64'd0 : header_len);
				restart();
				return;
			end
			case (parse_phase)
				PARSE_LENGTH: begin
					header_len[{field_count[2:0], 3'b000} +: 8] = b;
					crc_reg = crc32c_step(crc_reg, b);
					field_count++;
					if (field_count == 4'd8) begin
						parse_phase = PARSE_LENGTH_CRC;
						field_count = '0;
						crc_field   = '0;
					end
				end
				PARSE_LENGTH_CRC: begin
					crc_field[{field_count[1:0], 3'b000} +: 8] = b;
					field_count++;
					if (field_count == 4'd4) begin
						if (crc_field != crc32c_masked(crc_reg)) begin
							push_beat(KIND_STATUS, 8'd0, ST_LEN_CRC_ERR, header_len);
							restart();
						end else begin
							field_count = '0;
							crc_field   = '0;
							crc_reg     = CRC_INIT;
							bytes_left  = header_len;
							parse_phase = (header_len == 0) ? PARSE_PAYLOAD_CRC : PARSE_PAYLOAD;
						end
					end
				end
				PARSE_PAYLOAD: begin
					crc_reg = crc32c_step(crc_reg, b);
					bytes_left--;
					if (bytes_left == 0) begin
						parse_phase = PARSE_PAYLOAD_CRC;
						field_count = '0;
						crc_field   = '0;
					end
					push_beat(KIND_PAYLOAD, b, ST_OK, 64'd0);
				end
				default: begin
					crc_field[{field_count[1:0], 3'b000} +: 8] = b;
					field_count++;
					if (field_count == 4'd4) begin
						if (crc_field == crc32c_masked(crc_reg)) begin
							good_bytes += FRAME_BYTES + header_len;
							push_beat(KIND_STATUS, 8'd0, ST_OK, header_len);
						end else begin
							push_beat(KIND_STATUS, 8'd0, ST_PAY_CRC_ERR, header_len);
						end
						restart();
					end
				end
			endcase
		endfunction

		task report(input string what);
			errors++;
			$display("[%0t] mismatch on output beat %0d: %s", $time, beats_seen, what);
		endtask

		// Called for every beat accepted on the output side.
		task check_beat(input logic [OUT_TDATA_W-1:0] data, input logic user);
			deframe_beat_t want;
			beats_seen++;
			if (awaited_results.size() == 0) begin
				report($sformatf("no result expected, got tdata=%h tuser=%b", data, user));
				return;
			end
			want = awaited_results.pop_front();
			if (user !== want.kind)
				report($sformatf("kind %b, expected %b", user, want.kind));
			if (data[7:0] !== want.payload_byte)
				report($sformatf("payload_byte %h, expected %h", data[7:0], want.payload_byte));
			if (data[10:8] !== want.status)
				report($sformatf("status %0d, expected %s", data[10:8], want.status.name()));
			if (data[74:11] !== want.record_length)
				report($sformatf("record_length %h, expected %h", data[74:11],
					want.record_length));
			if (data[138:75] !== want.stream_offset)
				report($sformatf("stream_offset %h, expected %h", data[138:75],
					want.stream_offset));
			if (data[143:139] !== 5'd0)
				report($sformatf("padding bits %b are not zero", data[143:139]));
		endtask

		task check_drained();
			if (awaited_results.size() != 0)
				report($sformatf("%0d expected results never arrived", awaited_results.size()));
		endtask
	endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import rdmc_pkg::*;
	import deframer_check_pkg::*;

	// Run shape. The stimulus stops once about ITEM_TARGET beats went in; from
	// QUIET_FROM on neither side idles. After HOLD_AT beats the output side holds
	// off for a span set by HOLD_CYCLES so the result queue fills and the input stalls.
	localparam int ITEM_TARGET  = 1300;
	localparam int QUIET_FROM   = 1150;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata  = 8'd0;	// [7:0] in_byte
	logic                   s_axis_tlast  = 1'b0;	// end_of_stream
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [7:0] payload_byte, [10:8] status, [74:11] record_length,
	// [138:75] stream_offset, [143:139] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;	// kind

	deframe_tracker tracker;
	bit             idle_on   = 1'b1;
	bit             hold_req  = 1'b0;
	bit             hold_done = 1'b0;
	int unsigned    items_sent  = 0;
	int unsigned    cycle_count = 0;
	logic [7:0]     frame_q[$];

	record_deframer_masked_crc32c u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Both handshakes are observed in one process so that a beat going in is
	// always accounted for before any result at the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_beat(m_axis_tdata, m_axis_tuser);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Output side. Ready drops in random bursts while idling is enabled, and
	// once for a long hold-off that is timed here, independent of the sender.
	initial begin : sink_side
		int unsigned gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 8);
				m_axis_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offers one beat, possibly after a random gap, and returns at the falling
	// edge after it was taken. Inputs only ever change at falling edges.
	task automatic send_item(input logic [7:0] b, input logic eos);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tdata  <= b;
		s_axis_tlast  <= eos;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Sends the first count bytes of the frame being built and clears it.
	task automatic send_frame(input int unsigned count);
		int unsigned i;
		for (i = 0; i < count; i++)
			send_item(frame_q[i], 1'b0);
		frame_q.delete();
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Eight length bytes and the masked CRC over them; spoil flips one CRC bit.
	function automatic void add_header(input logic [63:0] len, input bit spoil);
		logic [31:0] crc;
		logic [31:0] field;
		int i;
		crc = CRC_INIT;
		for (i = 0; i < 8; i++) begin
			frame_q.push_back(len[8*i +: 8]);
			crc = crc32c_step(crc, len[8*i +: 8]);
		end
		field = crc32c_masked(crc);
		if (spoil)
			field ^= 32'd1 << $urandom_range(0, 31);
		for (i = 0; i < 4; i++)
			frame_q.push_back(field[8*i +: 8]);
	endfunction

	// Random payload followed by its masked CRC; spoil flips one CRC bit.
	function automatic void add_body(input int unsigned len, input bit spoil);
		logic [31:0] crc;
		logic [31:0] field;
		logic [7:0]  b;
		int unsigned i;
		crc = CRC_INIT;
		for (i = 0; i < len; i++) begin
			b = pick_byte();
			frame_q.push_back(b);
			crc = crc32c_step(crc, b);
		end
		field = crc32c_masked(crc);
		if (spoil)
			field ^= 32'd1 << $urandom_range(0, 31);
		for (i = 0; i < 4; i++)
			frame_q.push_back(field[8*i +: 8]);
	endfunction

	// Mostly short payloads keep the record count high; a few run longer.
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		else if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 95)
			return $urandom_range(9, 40);
		else
			return $urandom_range(41, 120);
	endfunction

	// A header length for a record whose length CRC is wrong. Most of these reach the
	// upper length bytes, which a good record could never use here.
	function automatic logic [63:0] pick_wild_length();
		case ($urandom_range(0, 3))
			0:       return {64{1'b1}};
			1:       return 64'($urandom_range(0, 40));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin : stimulus
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		int unsigned i;
		tracker = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: a stream that ends before any byte is a clean end, a record
		// with an empty payload is good, and a stream cut inside the length field
		// is truncated with no length to report.
		send_item(8'h00, 1'b1);
		add_header(64'd0, 1'b0);
		add_body(0, 1'b0);
		send_frame(frame_q.size());
		for (i = 0; i < 3; i++)
			send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);

		// Random part: mostly well-formed records with random content, mixed
		// with spoiled CRCs, cut-off streams, stream ends and plain noise.
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= QUIET_FROM)
				idle_on = 1'b0;
			else if ($urandom_range(0, 3) == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = pick_length();
				add_header(64'(len), 1'b0);
				add_body(len, 1'b0);
				send_frame(frame_q.size());
			end else if (pick < 67) begin
				// After a bad length CRC the parser expects a new header right away,
				// so only the twelve header bytes go out.
				add_header(pick_wild_length(), 1'b1);
				send_frame(frame_q.size());
			end else if (pick < 77) begin
				len = pick_length();
				add_header(64'(len), 1'b0);
				add_body(len, 1'b1);
				send_frame(frame_q.size());
			end else if (pick < 88) begin
				// Cut a good record at any point past its first byte, then end.
				len = pick_length();
				add_header(64'(len), 1'b0);
				add_body(len, 1'b0);
				cut = $urandom_range(1, frame_q.size() - 1);
				send_frame(cut);
				send_item(pick_byte(), 1'b1);
			end else if (pick < 94) begin
				send_item(pick_byte(), 1'b1);
			end else begin
				// Noise is followed by a stream end so the parser starts over.
				len = $urandom_range(1, 20);
				for (i = 0; i < len; i++)
					frame_q.push_back(8'($urandom_range(0, 255)));
				send_frame(frame_q.size());
				send_item(pick_byte(), 1'b1);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.awaited_results.size() != 0) @(posedge clk);
		// A further drain wait catches any result the block emits beyond the last one.
		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.check_drained();
		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
